[hdl/iplt_pkg.sv]
// Shared widths, tag type and clamp function for the attribute interpolator.
// No dependencies.
package iplt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int WT_W        = FRAC_BITS + 1;
  localparam int INVW_W      = 32;
  localparam int PW_W        = INVW_W + WT_W;          // inv_w * weight
  localparam int DEN_W       = PW_W + 1;               // sum of three
  localparam int REM_W       = DEN_W + 1;
  localparam int RECIP_W     = 32;
  localparam int VW_W        = VALUE_WIDTH + WT_W + 1; // signed value * weight
  localparam int SA_W        = VW_W + 2;
  localparam int TERM_W      = VALUE_WIDTH + PW_W + 1;
  localparam int SD_W        = TERM_W + 2;
  localparam int PROD_W      = SD_W + RECIP_W + 1;
  localparam int SD_HI_W     = SD_W - 2 * RECIP_W;

  localparam logic [1:0] REQ_PERSP  = 2'd0;
  localparam logic [1:0] REQ_AFFINE = 2'd1;
  localparam logic [1:0] REQ_FLAT   = 2'd2;
  localparam logic [1:0] REQ_DEPTH  = 2'd3;

  typedef struct packed {
    logic [1:0]                    req;
    logic [VALUE_WIDTH-1:0]        val_a;
    logic signed [SA_W-1:0]        sa;
    logic signed [SD_W-1:0]        sd;
  } iplt_tag_t;

  typedef struct packed {
    logic                   sat;
    logic [VALUE_WIDTH-1:0] val;
  } iplt_clamp_t;

  function automatic iplt_clamp_t iplt_clamp(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] maxv;
    logic signed [PROD_W-1:0] minv;
    iplt_clamp_t r;
    maxv = PROD_W'((PROD_W'(1) << (VALUE_WIDTH - 1)) - 1);
    minv = -maxv - PROD_W'(1);
    if (v > maxv) begin
      r.sat = 1'b1;
      r.val = maxv[VALUE_WIDTH-1:0];
    end else if (v < minv) begin
      r.sat = 1'b1;
      r.val = minv[VALUE_WIDTH-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/iplt_front.sv]
// Front end: weight products, denominator and numerator sums over four stages.
// Depends on iplt_pkg.
module iplt_front import iplt_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [1:0]                    req_type,
  input  logic                          is_line,
  input  logic [3*WT_W-1:0]             weights,
  input  logic [3*INVW_W-1:0]           inv_ws,
  input  logic [3*VALUE_WIDTH-1:0]      values,
  output logic                          out_valid,
  output logic [DEN_W-1:0]              den,
  output iplt_tag_t                     tag
);

  logic [3:0]                     vld;
  logic [1:0]                     req1, req2, req3;
  logic [VALUE_WIDTH-1:0]         va1, va2, va3;
  logic [PW_W-1:0]                pw [3];
  logic signed [VW_W-1:0]         vw [3];
  logic signed [VALUE_WIDTH-1:0]  val1 [3];
  logic [DEN_W-1:0]               den2, den3;
  logic signed [SA_W-1:0]         sa2, sa3;
  logic signed [VALUE_WIDTH+RECIP_W:0]   ppl [3];
  logic signed [VALUE_WIDTH+PW_W-RECIP_W+1:0] pph [3];
  logic signed [TERM_W-1:0]       term [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req1 <= req_type;
      va1  <= values[VALUE_WIDTH-1:0];
      for (int i = 0; i < 3; i++) begin
        logic [WT_W-1:0] w;
        w = (i == 2 && is_line) ? '0 : weights[i*WT_W +: WT_W];
        pw[i]   <= PW_W'(inv_ws[i*INVW_W +: INVW_W]) * PW_W'(w);
        vw[i]   <= VW_W'($signed(values[i*VALUE_WIDTH +: VALUE_WIDTH]) * $signed({1'b0, w}));
        val1[i] <= $signed(values[i*VALUE_WIDTH +: VALUE_WIDTH]);
      end
      req2 <= req1;
      va2  <= va1;
      den2 <= DEN_W'(pw[0]) + DEN_W'(pw[1]) + DEN_W'(pw[2]);
      sa2  <= SA_W'(vw[0]) + SA_W'(vw[1]) + SA_W'(vw[2]);
      for (int i = 0; i < 3; i++) begin
        ppl[i] <= val1[i] * $signed({1'b0, pw[i][RECIP_W-1:0]});
        pph[i] <= val1[i] * $signed({1'b0, pw[i][PW_W-1:RECIP_W]});
      end
      req3 <= req2;
      va3  <= va2;
      den3 <= den2;
      sa3  <= sa2;
      for (int i = 0; i < 3; i++) begin
        term[i] <= (TERM_W'(pph[i]) <<< RECIP_W) + TERM_W'(ppl[i]);
      end
      den     <= den3;
      tag.req <= req3;
      tag.val_a <= va3;
      tag.sa  <= sa3;
      tag.sd  <= SD_W'(term[0]) + SD_W'(term[1]) + SD_W'(term[2]);
    end
  end

  assign out_valid = vld[3];

endmodule

[hdl/iplt_recip.sv]
// Reciprocal of the denominator, one quotient bit per pipeline stage.
// Depends on iplt_pkg.
module iplt_recip import iplt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [DEN_W-1:0]    den,
  input  iplt_tag_t           in_tag,
  output logic                out_valid,
  output logic [RECIP_W-1:0]  recip,
  output logic                sat,
  output iplt_tag_t           out_tag
);

  typedef struct packed {
    logic [DEN_W-1:0]   d;
    logic [REM_W-1:0]   rem;
    logic [RECIP_W-1:0] q;
    logic               sat;
    iplt_tag_t          tag;
  } div_st_t;

  localparam logic [DEN_W-1:0] SAT_LIMIT = DEN_W'(1) << (3 * FRAC_BITS - RECIP_W);

  div_st_t            st [RECIP_W+1];
  logic [RECIP_W:1]   vld;

  always_comb begin
    st[0].d   = den;
    st[0].rem = REM_W'(SAT_LIMIT);
    st[0].q   = '0;
    st[0].sat = (den <= SAT_LIMIT);
    st[0].tag = in_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RECIP_W-1:1], in_valid};
    end
  end

  for (genvar k = 0; k < RECIP_W; k++) begin : g_stage
    logic [REM_W-1:0] trial;
    logic             ge;
    assign trial = {st[k].rem[REM_W-2:0], 1'b0};
    assign ge    = (trial >= REM_W'(st[k].d));

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].d   <= st[k].d;
        st[k+1].rem <= ge ? trial - REM_W'(st[k].d) : trial;
        st[k+1].q   <= {st[k].q[RECIP_W-2:0], ge};
        st[k+1].sat <= st[k].sat;
        st[k+1].tag <= st[k].tag;
      end
    end
  end

  assign out_valid = vld[RECIP_W];
  assign sat       = st[RECIP_W].sat;
  assign recip     = st[RECIP_W].sat ? '1 : st[RECIP_W].q;
  assign out_tag   = st[RECIP_W].tag;

endmodule

[hdl/iplt_back.sv]
// Back end: numerator times reciprocal, mode select, scaling and clamp.
// Depends on iplt_pkg.
module iplt_back import iplt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [RECIP_W-1:0]      recip,
  input  logic                    rsat,
  input  iplt_tag_t               tag,
  output logic                    out_valid,
  output logic [VALUE_WIDTH-1:0]  result_value,
  output logic [RECIP_W-1:0]      recip_inv_w,
  output logic                    saturated
);

  logic [2:0]                       vld;
  iplt_tag_t                        tag1, tag2;
  logic [RECIP_W-1:0]               r1, r2;
  logic                             s1, s2;
  logic [2*RECIP_W-1:0]             p_lo, p_mid;
  logic signed [SD_HI_W+RECIP_W:0]  p_hi;
  logic signed [PROD_W-1:0]         prod;
  logic signed [PROD_W-1:0]         pick;
  iplt_clamp_t                      cl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_comb begin
    case (tag2.req)
      REQ_AFFINE: pick = PROD_W'(tag2.sa) >>> FRAC_BITS;
      REQ_DEPTH:  pick = PROD_W'(tag2.sd) >>> (2 * FRAC_BITS);
      default:    pick = prod >>> (3 * FRAC_BITS);
    endcase
    cl = iplt_clamp(pick);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1  <= tag;
      r1    <= recip;
      s1    <= rsat;
      p_lo  <= tag.sd[RECIP_W-1:0] * recip;
      p_mid <= tag.sd[2*RECIP_W-1:RECIP_W] * recip;
      p_hi  <= $signed(tag.sd[SD_W-1:2*RECIP_W]) * $signed({1'b0, recip});
      tag2  <= tag1;
      r2    <= r1;
      s2    <= s1;
      prod  <= (PROD_W'(p_hi) <<< (2 * RECIP_W)) + (PROD_W'(p_mid) << RECIP_W)
               + PROD_W'(p_lo);
      recip_inv_w <= r2;
      if (tag2.req == REQ_FLAT) begin
        result_value <= tag2.val_a;
        saturated    <= s2;
      end else begin
        result_value <= cl.val;
        saturated    <= s2 | cl.sat;
      end
    end
  end

  assign out_valid = vld[2];

endmodule

[hdl/perspective_attribute_interpolator.sv]
// Perspective-correct attribute interpolator, Q16.16 fixed point.
// Pipeline: 4 product/sum stages, 32 reciprocal stages (one quotient bit each),
// 3 multiply/clamp stages. Throughput one beat per cycle; the whole pipe holds on stall.
// rst (synchronous) clears all valid bits; payload registers are not reset.
// Depends on iplt_pkg, iplt_front, iplt_recip, iplt_back.
module perspective_attribute_interpolator import iplt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // weight_a, weight_b, weight_c, inv_w_a, inv_w_b, inv_w_c, value_a, value_b, value_c
  input  logic [247:0] s_axis_tdata,
  // req_type, is_line
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value, recip_inv_w
  output logic [63:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser
);

  logic        en;
  logic        f_valid, d_valid;
  logic [DEN_W-1:0] f_den;
  iplt_tag_t   f_tag, d_tag;
  logic [RECIP_W-1:0] d_recip;
  logic        d_sat;

  assign en            = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = en;

  iplt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid & en),
    .req_type  (s_axis_tuser[1:0]),
    .is_line   (s_axis_tuser[2]),
    .weights   (s_axis_tdata[3*WT_W-1:0]),
    .inv_ws    (s_axis_tdata[3*WT_W +: 3*INVW_W]),
    .values    (s_axis_tdata[3*WT_W+3*INVW_W +: 3*VALUE_WIDTH]),
    .out_valid (f_valid),
    .den       (f_den),
    .tag       (f_tag)
  );

  iplt_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .den       (f_den),
    .in_tag    (f_tag),
    .out_valid (d_valid),
    .recip     (d_recip),
    .sat       (d_sat),
    .out_tag   (d_tag)
  );

  iplt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (d_valid),
    .recip        (d_recip),
    .rsat         (d_sat),
    .tag          (d_tag),
    .out_valid    (m_axis_tvalid),
    .result_value (m_axis_tdata[31:0]),
    .recip_inv_w  (m_axis_tdata[63:32]),
    .saturated    (m_axis_tuser)
  );

endmodule

[dv/perspective_attribute_interpolator_tb.sv]
// Self-checking testbench for the perspective-correct attribute interpolator.
// Drives fragment beats through a directed table and then random items, predicts each
// result locally and compares it with every output beat. Depends on iplt_pkg and the RTL.
`timescale 1ns / 1ps

module perspective_attribute_interpolator_tb;
  import iplt_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic        line;
    logic [16:0] wt[3];
    logic [31:0] iw[3];
    logic [31:0] val[3];
  } frag_t;

  typedef struct {
    logic [31:0] value;
    logic [31:0] recip;
    logic        sat;
  } interp_t;

  typedef struct {
    frag_t   frag;
    logic    known;
    interp_t want;
  } row_t;

  localparam int ONE = 65536;
  localparam int LIMIT = 500000;
  localparam int N_RANDOM = 1230;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [247:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  interp_t pending_results[$];
  int      errors = 0;
  int      accepted = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;
  bit      hold_off_done = 1'b0;
  row_t    rows[$];

  perspective_attribute_interpolator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic interp_t interpolate(frag_t f);
    localparam logic signed [191:0] VMAX = 192'sd2147483647;
    localparam logic signed [191:0] VMIN = -VMAX - 192'sd1;
    logic [63:0]         den;
    logic [127:0]        quo;
    logic [63:0]         factor;
    logic signed [191:0] acc;
    logic signed [191:0] scaled;
    int                  nv;
    interp_t             r;
    nv = f.line ? 2 : 3;
    den = '0;
    acc = '0;
    for (int i = 0; i < nv; i++) den += 64'(f.iw[i]) * 64'(f.wt[i]);
    r.sat = 1'b0;
    if (den == 0) begin
      r.recip = 32'hFFFF_FFFF;
      r.sat = 1'b1;
    end else begin
      quo = (128'd1 << (3 * FRAC_BITS)) / 128'(den);
      if (quo > 128'h FFFF_FFFF) begin
        r.recip = 32'hFFFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.recip = quo[31:0];
      end
    end
    for (int i = 0; i < nv; i++) begin
      factor = (f.req == REQ_AFFINE) ? 64'(f.wt[i]) : 64'(f.iw[i]) * 64'(f.wt[i]);
      acc += $signed({{160{f.val[i][31]}}, f.val[i]}) * $signed({128'b0, factor});
    end
    case (f.req)
      REQ_AFFINE: scaled = acc >>> FRAC_BITS;
      REQ_DEPTH:  scaled = acc >>> (2 * FRAC_BITS);
      default:    scaled = (acc * $signed({160'b0, r.recip})) >>> (3 * FRAC_BITS);
    endcase
    if (f.req == REQ_FLAT) begin
      r.value = f.val[0];
    end else if (scaled > VMAX) begin
      r.value = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (scaled < VMIN) begin
      r.value = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.value = scaled[31:0];
    end
    return r;
  endfunction

  function automatic frag_t make_frag(logic [1:0] req, logic line,
                                      int wa, int wb, int wc,
                                      logic [31:0] ia, logic [31:0] ib, logic [31:0] ic,
                                      logic [31:0] va, logic [31:0] vb, logic [31:0] vc);
    frag_t f;
    f.req = req;
    f.line = line;
    f.wt[0] = 17'(wa); f.wt[1] = 17'(wb); f.wt[2] = 17'(wc);
    f.iw[0] = ia; f.iw[1] = ib; f.iw[2] = ic;
    f.val[0] = va; f.val[1] = vb; f.val[2] = vc;
    return f;
  endfunction

  function automatic row_t row(frag_t f, logic known = 1'b0, logic [31:0] value = '0,
                               logic [31:0] recip = '0, logic sat = 1'b0);
    row_t r;
    r.frag = f;
    r.known = known;
    r.want.value = value;
    r.want.recip = recip;
    r.want.sat = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 4 * ONE));
      3:       return 32'($urandom_range(ONE / 64, 16 * ONE));
      default: return $urandom;
    endcase
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    int    wa, wb;
    f.req = 2'($urandom_range(0, 3));
    f.line = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 3; i++) f.wt[i] = 17'($urandom_range(0, ONE));
    end else begin
      wa = $urandom_range(0, ONE);
      wb = f.line ? ONE - wa : $urandom_range(0, ONE - wa);
      f.wt[0] = 17'(wa);
      f.wt[1] = 17'(wb);
      f.wt[2] = f.line ? 17'($urandom_range(0, ONE)) : 17'(ONE - wa - wb);
    end
    for (int i = 0; i < 3; i++) begin
      f.iw[i] = ($urandom_range(0, 2) == 0) ? rand_word() : 32'($urandom_range(ONE / 16, 4 * ONE));
      f.val[i] = ($urandom_range(0, 1) == 0) ? rand_word() : 32'($urandom_range(0, 200 * ONE)) - 32'(100 * ONE);
    end
    return f;
  endfunction

  task automatic send(frag_t f);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {5'b0, f.val[2], f.val[1], f.val[0], f.iw[2], f.iw[1], f.iw[0],
                    f.wt[2], f.wt[1], f.wt[0]};
    s_axis_tuser = {f.line, f.req};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    accepted++;
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps pushing
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_off_done && accepted > 400) begin
        hold_off_done = 1'b1;
        stall = 300;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    interp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: result_value %h", m_axis_tdata[31:0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.value) begin
          $error("result_value expected %h actual %h", want.value, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== want.recip) begin
          $error("recip_inv_w expected %h actual %h", want.recip, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tuser !== want.sat) begin
          $error("saturated expected %b actual %b", want.sat, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    frag_t   f;
    interp_t want;
    int      waited;
    rows.push_back(row(make_frag(REQ_PERSP, 1'b0, 0, 0, 0, 0, 0, 0, 32'h1234_5678, 1, 2),
                       1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1));
    rows.push_back(row(make_frag(REQ_FLAT, 1'b0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 5, 6),
                       1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
    rows.push_back(row(make_frag(REQ_AFFINE, 1'b1, 0, 0, ONE, ONE, ONE, ONE, 7, 8, 9),
                       1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1));
    rows.push_back(row(make_frag(REQ_DEPTH, 1'b0, 0, 0, 0, 5, 5, 5, 1, 2, 3),
                       1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1));
    rows.push_back(row(make_frag(REQ_PERSP, 1'b0, 21845, 21845, 21846, ONE, 2 * ONE, 4 * ONE,
                                 ONE, 2 * ONE, 3 * ONE)));
    rows.push_back(row(make_frag(REQ_AFFINE, 1'b0, 21845, 21845, 21846, ONE, ONE, ONE,
                                 32'hFFFF_0000, 0, ONE)));
    rows.push_back(row(make_frag(REQ_FLAT, 1'b1, ONE, 0, ONE, ONE, ONE, ONE,
                                 32'h7FFF_FFFF, 1, 2)));
    rows.push_back(row(make_frag(REQ_DEPTH, 1'b0, 32768, 16384, 16384, 2 * ONE, ONE, ONE / 2,
                                 32'hFFFF_8000, ONE / 2, ONE)));
    rows.push_back(row(make_frag(REQ_PERSP, 1'b1, 32768, 32768, ONE, ONE / 2, 8 * ONE, 0,
                                 10 * ONE, 32'hFFF6_0000, 99)));
    rows.push_back(row(make_frag(REQ_AFFINE, 1'b1, ONE, ONE, ONE, 1, 1, 1,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0)));
    rows.push_back(row(make_frag(REQ_AFFINE, 1'b0, ONE, ONE, ONE, ONE, ONE, ONE,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)));
    rows.push_back(row(make_frag(REQ_AFFINE, 1'b0, ONE, ONE, ONE, ONE, ONE, ONE,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000)));
    rows.push_back(row(make_frag(REQ_DEPTH, 1'b0, ONE, ONE, ONE,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000)));
    rows.push_back(row(make_frag(REQ_PERSP, 1'b0, ONE, ONE, ONE,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)));
    rows.push_back(row(make_frag(REQ_PERSP, 1'b0, 1, 0, 0, 1, 0, 0,
                                 32'h8000_0000, 0, 0)));
    rows.push_back(row(make_frag(REQ_PERSP, 1'b0, 1, 1, 1, 1, 1, 1,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)));
    rows.push_back(row(make_frag(REQ_DEPTH, 1'b1, 40000, 25536, ONE, 3 * ONE, ONE, 32'hFFFF_FFFF,
                                 32'hFFFF_0000, ONE, 32'h7FFF_FFFF)));
    rows.push_back(row(make_frag(REQ_PERSP, 1'b0, 0, 0, ONE, 0, 0, 32'hFFFF_FFFF,
                                 0, 0, 32'h8000_0000)));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      want = rows[i].known ? rows[i].want : interpolate(rows[i].frag);
      pending_results.push_back(want);
      send(rows[i].frag);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 50) quiet = ~quiet;
      f = rand_frag();
      pending_results.push_back(interpolate(f));
      send(f);
    end
    s_axis_tvalid = 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d results never arrived", pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
